@@ src/l11_pkg.sv @@
// Package for the LINEAR11 scaled converter.
// Holds the shared widths, status and mode codes and the pipeline payload type.
// Has no dependencies.
package l11_pkg;

	// Field widths of the stream beats.
	localparam int ValW   = 16;
	localparam int ScaleW = 16;
	localparam int StatW  = 2;

	// Internal arithmetic widths.
	localparam int CmpW  = 42;
	localparam int DenW  = 31;
	localparam int QuoW  = 10;
	localparam int ProdW = 26;

	// Number of exponent candidates (-16..15).
	localparam int NumExp = 32;

	// Status codes.
	localparam logic [StatW-1:0] StOk    = 2'd0;
	localparam logic [StatW-1:0] StZero  = 2'd1;
	localparam logic [StatW-1:0] StSat   = 2'd2;

	// Mode codes.
	localparam logic ModeEnc = 1'b0;
	localparam logic ModeDec = 1'b1;

	// Payload that travels through the divider stages.
	typedef struct packed {
		logic              dec;
		logic [StatW-1:0]  status;
		logic [ValW-1:0]   dres;
		logic [4:0]        expo;
		logic [CmpW-1:0]   rem;
		logic [DenW-1:0]   den;
		logic [QuoW-1:0]   quo;
	} pipe_t;

endpackage

@@ src/l11_front.sv @@
// Front end of the converter: exponent search, decode multiply and shift.
// Two register stages; depends on l11_pkg.
module l11_front (
	input  logic                      clk,
	input  logic                      en_s1,
	input  logic                      en_s2,
	input  logic                      mode,
	input  logic [l11_pkg::ValW-1:0]  value,
	input  logic [l11_pkg::ScaleW-1:0] scale,
	output l11_pkg::pipe_t            p_s2
);

	logic                       mode_s1;
	logic [l11_pkg::ValW-1:0]   val_s1;
	logic [l11_pkg::ScaleW-1:0] scl_s1;
	logic [l11_pkg::NumExp-1:0] fit_s1;
	logic [l11_pkg::ProdW-1:0]  prod_s1;
	logic                       mnz_s1;
	logic [l11_pkg::NumExp-1:0] fit;

	// For each exponent, check whether the rounded mantissa stays at or below 1023.
	always_comb begin
		logic [l11_pkg::CmpW-1:0] lhs;
		logic [l11_pkg::CmpW-1:0] rhs;
		for (int i = 0; i < l11_pkg::NumExp; i++) begin
			if (i <= 16) begin
				lhs = ({26'b0, value} << (16 - i)) + {27'b0, scale[15:1]};
				rhs = {26'b0, scale} << 10;
			end else begin
				lhs = {26'b0, value} + ({26'b0, scale} << (i - 17));
				rhs = {26'b0, scale} << (i - 6);
			end
			fit[i] = (lhs < rhs);
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1 <= mode;
			val_s1  <= value;
			scl_s1  <= scale;
			fit_s1  <= fit;
			prod_s1 <= value[9:0] * scale;
			mnz_s1  <= value[10] || (value[10:0] == 11'd0);
		end
	end

	l11_pkg::pipe_t nxt;

	// Stage 2: choose the exponent, set up the division, finish decode.
	always_comb begin
		logic [4:0]  sel;
		logic [4:0]  ebits;
		logic [5:0]  sh;
		logic [40:0] full;
		logic [26:0] rnd;
		logic        sat;
		sel   = 5'd31;
		ebits = val_s1[15:11];
		sh    = 6'd0;
		full  = '0;
		rnd   = '0;
		for (int i = l11_pkg::NumExp - 1; i >= 0; i--) begin
			if (fit_s1[i]) begin
				sel = i[4:0];
			end
		end
		nxt.expo = {~sel[4], sel[3:0]};
		nxt.quo  = '0;
		if (sel <= 5'd16) begin
			nxt.rem = ({26'b0, val_s1} << (5'd16 - sel)) + {27'b0, scl_s1[15:1]};
			nxt.den = {15'b0, scl_s1};
		end else begin
			nxt.rem = {26'b0, val_s1} + ({26'b0, scl_s1} << (sel - 5'd17));
			nxt.den = {15'b0, scl_s1} << (sel - 5'd16);
		end
		// Decode: shift the product by the signed exponent, rounding half up.
		if (!ebits[4]) begin
			full = {15'b0, prod_s1} << ebits[3:0];
			sat  = |full[40:16];
			nxt.dres = sat ? '1 : full[15:0];
		end else begin
			sh  = 6'd32 - {1'b0, ebits};
			rnd = ({1'b0, prod_s1} + (27'd1 << (sh - 6'd1))) >> sh;
			sat = |rnd[26:16];
			nxt.dres = sat ? '1 : rnd[15:0];
		end
		if (mnz_s1) begin
			sat = 1'b0;
			nxt.dres = '0;
		end
		nxt.dec    = mode_s1;
		nxt.status = (mode_s1 == l11_pkg::ModeDec && sat) ? l11_pkg::StSat : l11_pkg::StOk;
		if (scl_s1 == '0) begin
			nxt.dec    = l11_pkg::ModeDec;
			nxt.dres   = '0;
			nxt.status = l11_pkg::StZero;
		end
	end

	// Stage 2 registers.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_s2 <= nxt;
		end
	end

endmodule

@@ src/l11_div_stage.sv @@
// One divider stage: two restoring quotient steps, then a register.
// Depends on l11_pkg.
module l11_div_stage #(
	parameter int Hi = 9
) (
	input  logic           clk,
	input  logic           en,
	input  l11_pkg::pipe_t pin,
	output l11_pkg::pipe_t pout
);

	l11_pkg::pipe_t nxt;

	// Two compare and subtract steps, top quotient bit first.
	always_comb begin
		logic [l11_pkg::CmpW-1:0] dsh;
		nxt = pin;
		for (int j = Hi; j > Hi - 2; j--) begin
			dsh = {11'b0, nxt.den} << j;
			if (nxt.rem >= dsh) begin
				nxt.rem    = nxt.rem - dsh;
				nxt.quo[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pout <= nxt;
		end
	end

endmodule

@@ src/linear11_scaled_converter_unit.sv @@
// LINEAR11 scaled converter: encodes value/scale into a LINEAR11 word or decodes
// a word back to a scaled integer. Uses l11_pkg, l11_front and l11_div_stage.
//
// Usage:
// The input channel takes one beat per conversion: tdata holds value and
// scale, tuser holds the mode (0 encode, 1 decode). The output channel gives
// one beat per input beat, in order, with the result and a status code
// (0 ok, 1 zero scale, 2 saturated to 65535).
// The datapath is eight register stages: exponent search and decode
// multiply, exponent select and decode shift, five divider stages of two
// quotient bits each, and the output register. m_tvalid rises once a beat
// has reached the output register; while m_tready stays high, one beat is
// accepted every cycle.
// Each stage advances when the stage after it is empty or moving, so
// bubbles are squeezed out while the receiver stalls and s_tready falls
// only when every stage holds a beat.
// Reset clears all stage valid bits; the data registers are not reset.
module linear11_scaled_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[15:0], scale[31:16]
	input  logic [0:0]  s_tuser,  // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // result[15:0], status[17:16], zero pad[23:18]
);

	localparam int NumSt = 8;

	logic [NumSt-1:0] vld_q;
	logic [NumSt-1:0] en;

	// Stage enables: a stage loads when it is empty or its successor moves.
	always_comb begin
		en[NumSt-1] = !vld_q[NumSt-1] || m_tready;
		for (int i = NumSt - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign s_tready = en[0];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NumSt; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	l11_pkg::pipe_t p_s2;
	l11_pkg::pipe_t div_s[0:5];

	l11_front u_front (
		.clk   (clk),
		.en_s1 (en[0]),
		.en_s2 (en[1]),
		.mode  (s_tuser[0]),
		.value (s_tdata[15:0]),
		.scale (s_tdata[31:16]),
		.p_s2  (p_s2)
	);

	assign div_s[0] = p_s2;

	// Divider stages, two quotient bits each.
	for (genvar g = 0; g < 5; g++) begin : g_div
		l11_div_stage #(
			.Hi (9 - 2 * g)
		) u_div (
			.clk  (clk),
			.en   (en[2+g]),
			.pin  (div_s[g]),
			.pout (div_s[g+1])
		);
	end

	logic [15:0]               result_s8;
	logic [l11_pkg::StatW-1:0] status_s8;

	// Output register: pack the encode word or pass the decode value.
	always_ff @(posedge clk) begin
		if (en[NumSt-1]) begin
			result_s8 <= div_s[5].dec ? div_s[5].dres : {div_s[5].expo, 1'b0, div_s[5].quo};
			status_s8 <= div_s[5].status;
		end
	end

	assign m_tvalid = vld_q[NumSt-1];
	assign m_tdata  = {6'b0, status_s8, result_s8};

	// The input side only stalls when every stage holds a beat.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q) && !m_tready)
		else $error("input stalled with an empty stage");

	// Status is never the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_s8 == l11_pkg::StOk || status_s8 == l11_pkg::StZero ||
			status_s8 == l11_pkg::StSat))
		else $error("illegal status code");

	// Zero scale always delivers a zero result.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_s8 == l11_pkg::StZero |-> result_s8 == 16'd0)
		else $error("zero scale with nonzero result");

	// The divider leaves a remainder below the divisor for encode beats.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[6] && !div_s[5].dec |-> div_s[5].rem < {11'b0, div_s[5].den})
		else $error("divider remainder out of range");

	// Saturation shows the all-ones result.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_s8 == l11_pkg::StSat |-> result_s8 == 16'hffff)
		else $error("saturated beat without full-scale result");

endmodule
